// ----- sv/fifo_assoc_render_cache_defines.svh -----
// ----------------------------------------------------------------------------
// fifo_assoc_render_cache_defines.svh
// Assertion macros shared by the render cache checker.
// ----------------------------------------------------------------------------
`ifndef FIFO_ASSOC_RENDER_CACHE_DEFINES_SVH
`define FIFO_ASSOC_RENDER_CACHE_DEFINES_SVH

// Same-cycle implication, off during reset.
`define FRC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, off during reset.
`define FRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication that also watches reset itself.
`define FRC_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- sv/frc_pkg.sv -----
// ----------------------------------------------------------------------------
// frc_pkg
// Types and constants of the FIFO-replacement render cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frc_pkg;

  localparam int DEF_ENTRIES  = 32;
  localparam int DEF_REF_BITS = 32;
  localparam int FIELD_W      = 32;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_ADD    = 2'd1,
    OP_UPDATE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } st_t;

endpackage

// ----- sv/frc_if.sv -----
// ----------------------------------------------------------------------------
// frc_in_if / frc_out_if
// Request and result channels, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface frc_in_if import frc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  op_t                  opcode;
  logic [FIELD_W-1:0]   object_key;
  logic [FIELD_W-1:0]   bitmap_ref;
  logic [FIELD_W-1:0]   font_tag;
  logic                 gc_done;

  modport source (output valid, opcode, object_key, bitmap_ref, font_tag, gc_done,
                  input ready);
  modport sink   (input valid, opcode, object_key, bitmap_ref, font_tag, gc_done,
                  output ready);
endinterface

interface frc_out_if import frc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [FIELD_W-1:0]   bitmap_out;

  modport source (output valid, hit, bitmap_out, input ready);
  modport sink   (input valid, hit, bitmap_out, output ready);
endinterface

// ----- sv/frc_mem.sv -----
// ----------------------------------------------------------------------------
// frc_mem
// Slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frc_mem import frc_pkg::*; #(
  parameter int DEPTH = DEF_ENTRIES,
  parameter int WIDTH = 3 * DEF_REF_BITS,
  parameter int AW    = $clog2(DEF_ENTRIES)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/frc_ctrl.sv -----
// ----------------------------------------------------------------------------
// frc_ctrl
// Request sequencer: slot pointer, linear scan over the store, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frc_ctrl import frc_pkg::*; #(
  parameter int ENTRIES  = DEF_ENTRIES,
  parameter int REF_BITS = DEF_REF_BITS,
  parameter int AW       = $clog2(DEF_ENTRIES)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  frc_in_if.sink                in_ch,
  frc_out_if.source             out_ch,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [3*REF_BITS-1:0] mem_wdata,
  output logic [AW-1:0]         mem_raddr,
  input  logic [3*REF_BITS-1:0] mem_rdata
);

  localparam int LW = AW + 1;
  localparam logic [LW-1:0] LIM_FULL = LW'(ENTRIES);
  localparam logic [LW-1:0] LAST_SLOT = LW'(ENTRIES - 1);

  st_t                  state_r, state_nxt;
  logic [AW-1:0]        slot_r, slot_nxt;
  logic                 full_r, full_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [LW-1:0]        lim_r, lim_nxt;
  op_t                  op_r, op_nxt;
  logic [REF_BITS-1:0]  key_r, key_nxt;
  logic [REF_BITS-1:0]  bmp_r, bmp_nxt;
  logic [REF_BITS-1:0]  font_r, font_nxt;
  logic                 res_hit_r, res_hit_nxt;
  logic [FIELD_W-1:0]   res_bmp_r, res_bmp_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic [FIELD_W-1:0]   out_bmp_r, out_bmp_nxt;

  logic [AW-1:0]        base_slot;
  logic                 base_full;
  logic [LW-1:0]        base_lim;
  logic [REF_BITS-1:0]  in_key, in_bmp, in_font;
  logic [REF_BITS-1:0]  rd_key, rd_bmp, rd_font;
  logic                 last_idx;

  assign in_key  = REF_BITS'(in_ch.object_key);
  assign in_bmp  = REF_BITS'(in_ch.bitmap_ref);
  assign in_font = REF_BITS'(in_ch.font_tag);
  assign rd_key  = mem_rdata[REF_BITS-1:0];
  assign rd_bmp  = mem_rdata[2*REF_BITS-1:REF_BITS];
  assign rd_font = mem_rdata[3*REF_BITS-1:2*REF_BITS];

  assign base_slot = in_ch.gc_done ? '0 : slot_r;
  assign base_full = in_ch.gc_done ? 1'b0 : full_r;
  assign base_lim  = base_full ? LIM_FULL : {1'b0, base_slot};
  assign last_idx  = (({1'b0, idx_r} + LW'(1)) == lim_r);

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.bitmap_out = out_bmp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    lim_r     <= lim_nxt;
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    bmp_r     <= bmp_nxt;
    font_r    <= font_nxt;
    res_hit_r <= res_hit_nxt;
    res_bmp_r <= res_bmp_nxt;
    out_hit_r <= out_hit_nxt;
    out_bmp_r <= out_bmp_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    full_nxt      = full_r;
    idx_nxt       = idx_r;
    lim_nxt       = lim_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    bmp_nxt       = bmp_r;
    font_nxt      = font_r;
    res_hit_nxt   = res_hit_r;
    res_bmp_nxt   = res_bmp_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_hit_nxt   = out_hit_r;
    out_bmp_nxt   = out_bmp_r;
    mem_we        = 1'b0;
    mem_waddr     = slot_r;
    mem_wdata     = {font_r, bmp_r, key_r};
    mem_raddr     = AW'({1'b0, idx_r} + LW'(1));

    unique case (state_r)
      ST_IDLE: begin
        mem_raddr = '0;
        if (in_ch.valid) begin
          op_nxt      = in_ch.opcode;
          key_nxt     = in_key;
          bmp_nxt     = in_bmp;
          font_nxt    = in_font;
          idx_nxt     = '0;
          lim_nxt     = base_lim;
          slot_nxt    = base_slot;
          full_nxt    = base_full;
          res_hit_nxt = 1'b0;
          res_bmp_nxt = '0;
          state_nxt   = ST_RESP;
          unique case (in_ch.opcode)
            OP_FIND: begin
              if (!in_ch.gc_done && base_lim != '0) begin
                state_nxt = ST_SCAN;
              end
            end
            OP_UPDATE: begin
              if (base_lim != '0) begin
                state_nxt = ST_SCAN;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = base_slot;
                mem_wdata = {in_font, in_bmp, in_key};
                slot_nxt  = AW'({1'b0, base_slot} + LW'(1));
              end
            end
            OP_ADD: begin
              mem_we    = 1'b1;
              mem_waddr = base_slot;
              mem_wdata = {in_font, in_bmp, in_key};
              if ({1'b0, base_slot} == LAST_SLOT) begin
                slot_nxt = '0;
                full_nxt = 1'b1;
              end else begin
                slot_nxt = AW'({1'b0, base_slot} + LW'(1));
              end
            end
            OP_CLEAR: begin
              slot_nxt = '0;
              full_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        idx_nxt = AW'({1'b0, idx_r} + LW'(1));
        if (op_r == OP_FIND) begin
          if (rd_key == key_r && rd_font == font_r) begin
            res_hit_nxt = 1'b1;
            res_bmp_nxt = FIELD_W'(rd_bmp);
            state_nxt   = ST_RESP;
          end else if (last_idx) begin
            state_nxt = ST_RESP;
          end
        end else begin
          if (rd_key == key_r) begin
            mem_we      = 1'b1;
            mem_waddr   = idx_r;
            res_hit_nxt = 1'b1;
            state_nxt   = ST_RESP;
          end else if (last_idx) begin
            // no key match: append at the pointer
            mem_we    = 1'b1;
            mem_waddr = slot_r;
            state_nxt = ST_RESP;
            if ({1'b0, slot_r} == LAST_SLOT) begin
              slot_nxt = '0;
              full_nxt = 1'b1;
            end else begin
              slot_nxt = AW'({1'b0, slot_r} + LW'(1));
            end
          end
        end
      end

      ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_bmp_nxt   = res_bmp_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- sv/fifo_assoc_render_cache.sv -----
// ----------------------------------------------------------------------------
// fifo_assoc_render_cache
// Fully associative render cache with round-robin slot replacement.
// ----------------------------------------------------------------------------
// One request at a time is taken. Add, clear, and a find or update-or-add that
// meets an empty cache, as after a garbage-collection pulse, skip the scan and
// go straight to loading the result register; no new request is taken before
// the previous result is loaded. Find and update-or-add otherwise walk the
// filled slots one per cycle through the single read port of the slot store
// before they load the result register, n slots in all, n being the slot
// index of the first match plus one, or the number of filled slots on a miss
// (at most ENTRIES, 32 at the default size). The result register frees the
// store for the next request while a result waits to be taken; a finished
// result that finds the register still occupied holds the block, and its
// input, until the waiting result is taken. There is no clearing pass after
// reset.
`timescale 1ns / 1ps

module fifo_assoc_render_cache import frc_pkg::*; #(
  parameter int ENTRIES  = DEF_ENTRIES,
  parameter int REF_BITS = DEF_REF_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  frc_in_if.sink     in_ch,
  frc_out_if.source  out_ch
);

  localparam int AW = $clog2(ENTRIES);
  localparam int DW = 3 * REF_BITS;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  frc_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (DW),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  frc_ctrl #(
    .ENTRIES  (ENTRIES),
    .REF_BITS (REF_BITS),
    .AW       (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

// ----- sv/frc_checker.sv -----
// ----------------------------------------------------------------------------
// frc_checker
// Port-level checks of the render cache, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fifo_assoc_render_cache_defines.svh"

module frc_checker import frc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_hit,
  input logic [FIELD_W-1:0] out_bitmap
);

  `FRC_ASSERT_RST(a_rst_idle, !rst_n, !out_valid)
  `FRC_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `FRC_ASSERT_NOW(a_miss_zero, out_valid && !out_hit, out_bitmap == '0)
  `FRC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `FRC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_bitmap))

endmodule

bind fifo_assoc_render_cache frc_checker u_frc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_hit    (out_ch.hit),
  .out_bitmap (out_ch.bitmap_out)
);

// ----- tb/frc_render_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frc_render_check
// Watches both channels of the render cache, keeps its own copy of the slot
// store, and checks every result against the answer due for the oldest
// accepted request. Mismatches and pending answers go back to the top.
// ----------------------------------------------------------------------------

module frc_render_check import frc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  frc_in_if    in_mon,
  frc_out_if   out_mon,
  output int   mismatches,
  output int   outstanding,
  output int   results_checked,
  output int   hits_seen
);

  typedef struct packed {
    logic               hit;
    logic [FIELD_W-1:0] bitmap;
  } answer_t;

  logic [FIELD_W-1:0] slot_key    [DEF_ENTRIES];
  logic [FIELD_W-1:0] slot_bitmap [DEF_ENTRIES];
  logic [FIELD_W-1:0] slot_font   [DEF_ENTRIES];
  int unsigned        fill_ptr;
  bit                 wrapped;
  answer_t            answers_due[$];

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void store_next(input logic [FIELD_W-1:0] key, bmp, font);
    slot_key[fill_ptr]    = key;
    slot_bitmap[fill_ptr] = bmp;
    slot_font[fill_ptr]   = font;
    if (fill_ptr == DEF_ENTRIES - 1) begin
      fill_ptr = 0;
      wrapped  = 1'b1;
    end else begin
      fill_ptr++;
    end
  endfunction

  // gc empties before the opcode acts; only filled slots are searched
  function automatic answer_t cache_answer(input op_t op,
                                           input logic [FIELD_W-1:0] key, bmp, font,
                                           input logic gc);
    answer_t     ans;
    int unsigned span;
    ans = '0;
    if (gc) begin
      fill_ptr = 0;
      wrapped  = 1'b0;
    end
    span = wrapped ? DEF_ENTRIES : fill_ptr;
    case (op)
      OP_FIND: begin
        for (int i = 0; i < span; i++) begin
          if (slot_key[i] == key && slot_font[i] == font) begin
            ans.hit    = 1'b1;
            ans.bitmap = slot_bitmap[i];
            break;
          end
        end
      end
      OP_ADD: begin
        store_next(key, bmp, font);
      end
      OP_UPDATE: begin
        for (int i = 0; i < span; i++) begin
          if (slot_key[i] == key) begin
            slot_bitmap[i] = bmp;
            slot_font[i]   = font;
            ans.hit        = 1'b1;
            break;
          end
        end
        if (!ans.hit) store_next(key, bmp, font);
      end
      default: begin
        fill_ptr = 0;
        wrapped  = 1'b0;
      end
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      fill_ptr = 0;
      wrapped  = 1'b0;
      answers_due.delete();
      for (int i = 0; i < DEF_ENTRIES; i++) begin
        slot_key[i]    = '0;
        slot_bitmap[i] = '0;
        slot_font[i]   = '0;
      end
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        results_checked++;
        if (out_mon.hit === 1'b1) hits_seen++;
        if (answers_due.size() == 0) begin
          flag_mismatch("result with no request pending");
        end else begin
          want = answers_due.pop_front();
          if (out_mon.hit !== want.hit)
            flag_mismatch($sformatf("hit got %b want %b", out_mon.hit, want.hit));
          if (out_mon.bitmap_out !== want.bitmap)
            flag_mismatch($sformatf("bitmap_out got %h want %h",
                                    out_mon.bitmap_out, want.bitmap));
        end
      end
      if (in_mon.valid && in_mon.ready)
        answers_due.push_back(cache_answer(in_mon.opcode, in_mon.object_key,
                                           in_mon.bitmap_ref, in_mon.font_tag,
                                           in_mon.gc_done));
    end
    outstanding = answers_due.size();
  end

endmodule

// ----- tb/fifo_assoc_render_cache_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_assoc_render_cache_test
// Drives find / add / update-or-add / clear requests with gc pulses into the
// render cache: a directed opening, then random sessions that can fill and wrap
// the cache before a clear or gc ends them. Both sides idle at random, the
// result side holds off once for a long stretch, and the sender drains mid-run and at the end.
// ----------------------------------------------------------------------------

module fifo_assoc_render_cache_test;
  import frc_pkg::*;

  localparam int RANDOM_REQUESTS = 2000;
  localparam int STALL_SPAN      = 300;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int DRAIN_CYCLES    = 40;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  frc_in_if  in_ch();
  frc_out_if out_ch();

  int mismatches;
  int outstanding;
  int results_checked;
  int hits_seen;

  bit hold_off_pending = 1'b0;
  bit steady_phase     = 1'b0;
  int op_tally[4];
  int gc_tally;

  logic [FIELD_W-1:0] key_pool  [10];
  logic [FIELD_W-1:0] font_pool [3];

  fifo_assoc_render_cache dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  frc_render_check model_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .hits_seen       (hits_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic offer(input op_t op, input logic [FIELD_W-1:0] key, bmp, font,
                       input logic gc);
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.object_key <= key;
    in_ch.bitmap_ref <= bmp;
    in_ch.font_tag   <= font;
    in_ch.gc_done    <= gc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    op_tally[op]++;
    if (gc) gc_tally++;
    if (!steady_phase && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 13);
    end
  endtask

  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [FIELD_W-1:0] pick_key();
    if ($urandom_range(3) == 0) return $urandom();
    return key_pool[$urandom_range(9)];
  endfunction

  function automatic logic [FIELD_W-1:0] pick_font();
    if ($urandom_range(99) < 15) return $urandom();
    return font_pool[$urandom_range(2)];
  endfunction

  function automatic logic [FIELD_W-1:0] pick_bitmap();
    case ($urandom_range(19))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic op_t pick_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return OP_FIND;
    if (r < 72) return OP_ADD;
    return OP_UPDATE;
  endfunction

  // result side: random stalls, a steady stretch, one long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (STALL_SPAN - 1) @(posedge clk);
      end else begin
        out_ch.ready <= steady_phase || ($urandom_range(99) >= 13);
      end
    end
  end

  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_run = 0;
      else
        idle_run++;
    end
    $display("watchdog: %0d cycles with no request or result moving", idle_run);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int   sent;
    int   session_len;
    op_t  op;
    logic gc;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_FIND;
    in_ch.object_key <= '0;
    in_ch.bitmap_ref <= '0;
    in_ch.font_tag   <= '0;
    in_ch.gc_done    <= 1'b0;
    key_pool[0]  = '0;
    key_pool[1]  = '1;
    for (int i = 2; i < 10; i++) key_pool[i] = $urandom();
    font_pool[0] = '0;
    font_pool[1] = '1;
    font_pool[2] = $urandom();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening
    offer(OP_FIND,   32'h0,         32'h0,         32'h0,         1'b0);
    offer(OP_ADD,    32'h0,         32'h0,         32'h0,         1'b0);
    offer(OP_FIND,   32'h0,         32'hFFFF_FFFF, 32'h0,         1'b0);
    offer(OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    offer(OP_FIND,   32'hFFFF_FFFF, 32'h0,         32'hFFFF_FFFF, 1'b0);
    offer(OP_FIND,   32'hFFFF_FFFF, 32'h0,         32'h0,         1'b0);
    offer(OP_UPDATE, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0,         1'b0);
    offer(OP_FIND,   32'hFFFF_FFFF, 32'h0,         32'h0,         1'b0);
    offer(OP_ADD,    32'h5A5A_5A5A, 32'h0000_0001, 32'h0F0F_0F0F, 1'b0);
    offer(OP_ADD,    32'h5A5A_5A5A, 32'h0000_0002, 32'hF0F0_F0F0, 1'b0);
    offer(OP_FIND,   32'h5A5A_5A5A, 32'h0,         32'hF0F0_F0F0, 1'b0);
    offer(OP_UPDATE, 32'h5A5A_5A5A, 32'h0000_0003, 32'hF0F0_F0F0, 1'b0);
    offer(OP_FIND,   32'h5A5A_5A5A, 32'h0,         32'hF0F0_F0F0, 1'b0);
    offer(OP_UPDATE, 32'hC3C3_C3C3, 32'h8000_0000, 32'h0000_0001, 1'b0);
    offer(OP_FIND,   32'hC3C3_C3C3, 32'h0,         32'h0000_0001, 1'b0);
    offer(OP_FIND,   32'hC3C3_C3C3, 32'h0,         32'h0000_0001, 1'b1);
    offer(OP_FIND,   32'h0,         32'h0,         32'h0,         1'b0);
    offer(OP_ADD,    32'h1,         32'h2,         32'h3,         1'b1);
    offer(OP_UPDATE, 32'h1,         32'h4,         32'h3,         1'b1);
    offer(OP_FIND,   32'h1,         32'h0,         32'h3,         1'b0);
    offer(OP_CLEAR,  32'h1,         32'h0,         32'h3,         1'b0);
    offer(OP_FIND,   32'h1,         32'h0,         32'h3,         1'b0);
    offer(OP_ADD,    32'h7,         32'h7,         32'h7,         1'b0);
    offer(OP_CLEAR,  32'h7,         32'h7,         32'h7,         1'b1);
    offer(OP_FIND,   32'h7,         32'h0,         32'h7,         1'b0);

    // random sessions, each closed by a clear or a gc pulse
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      session_len = $urandom_range(20, 150);
      for (int j = 0; j < session_len && sent < RANDOM_REQUESTS; j++) begin
        op = pick_op();
        gc = 1'b0;
        if (j == session_len - 1) begin
          if ($urandom_range(1) == 0) begin
            op = OP_CLEAR;
            gc = 1'($urandom_range(1));
          end else begin
            op = op_t'($urandom_range(3));
            gc = 1'b1;
          end
        end else if ($urandom_range(99) == 0) begin
          op = OP_CLEAR;
        end
        if (sent == 600) hold_off_pending = 1'b1;
        if (sent == 1000) wait_for_drain();
        steady_phase = (sent >= 1200 && sent < 1500);
        offer(op, pick_key(), pick_bitmap(), pick_font(), gc);
        sent++;
      end
    end
    steady_phase = 1'b0;

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d find, %0d add, %0d update-or-add, %0d clear, %0d gc",
             op_tally[OP_FIND] + op_tally[OP_ADD] + op_tally[OP_UPDATE] + op_tally[OP_CLEAR],
             op_tally[OP_FIND], op_tally[OP_ADD], op_tally[OP_UPDATE], op_tally[OP_CLEAR],
             gc_tally);
    $display("%0d results checked, %0d hits, one %0d-cycle result stall, one mid-run drain",
             results_checked, hits_seen, STALL_SPAN);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
